// ----- sv/pba_pkg.sv -----
// Shared types, codes and mask helpers for the page bitmap allocator.
package pba_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned PAGE_W        = 12;
    localparam int unsigned COUNT_W       = 13;
    localparam int unsigned WIDX_W        = 7;
    localparam int unsigned NUM_PAGES_DEF = 4096;

    localparam logic [COUNT_W-1:0] TOTAL_RESET = 13'd4096;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_MARK  = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [PAGE_W-1:0]  page_index;
        logic [COUNT_W-1:0] page_count;
    } t_request;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] found_page;
        logic              any_used;
    } t_result;

    typedef struct packed {
        logic               hit;
        logic [PAGE_W-1:0]  found;
        logic [COUNT_W-1:0] run;
    } t_scan;

    // n ones from bit 0 up, n in 0..32
    function automatic logic [WORD_W-1:0] low_mask(input logic [5:0] n);
        logic [WORD_W-1:0] m;
        if (n >= 6'd32) begin
            m = '1;
        end else begin
            m = (32'd1 << n) - 32'd1;
        end
        return m;
    endfunction

    // ones on bits lo..hi inclusive
    function automatic logic [WORD_W-1:0] range_mask(input logic [4:0] lo,
                                                     input logic [4:0] hi);
        return low_mask({1'b0, hi} + 6'd1) & ~low_mask({1'b0, lo});
    endfunction

endpackage

// ----- sv/pba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pba_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/pba_scan.sv -----
// First-fit evaluation of one bitmap word: run hit, start page and carried run.
module pba_scan import pba_pkg::*; (
    input  logic [WORD_W-1:0]  i_word,
    input  logic [WIDX_W-1:0]  i_word_idx,
    input  logic [COUNT_W-1:0] i_run,
    input  logic [COUNT_W-1:0] i_count,
    input  logic [COUNT_W-1:0] i_limit,
    output t_scan              o_res
);

    logic [WORD_W-1:0]  lim_mask;
    logic [WORD_W-1:0]  used;
    logic [5:0]         win_len;
    logic [COUNT_W-1:0] need;
    logic [WORD_W-1:0]  hit_vec;
    logic [4:0]         sel;
    logic [4:0]         top_used;
    logic [COUNT_W-1:0] start_pg;

    // pages at or past the limit count as used
    always_comb begin
        if ({1'b0, i_word_idx} < i_limit[12:5]) begin
            lim_mask = '0;
        end else if ({1'b0, i_word_idx} == i_limit[12:5]) begin
            lim_mask = ~low_mask({1'b0, i_limit[4:0]});
        end else begin
            lim_mask = '1;
        end
    end

    assign used    = i_word | lim_mask;
    assign win_len = (i_count > 13'd31) ? 6'd32 : 6'(i_count);
    assign need    = i_count - i_run;

    // bit j ends a fit if the in-word window ending at it is free and the
    // free run carried in from lower words covers the rest
    always_comb begin
        logic [5:0]        top;
        logic [5:0]        lo;
        logic [WORD_W-1:0] win;
        for (int j = 0; j < WORD_W; j++) begin
            top = 6'(j + 1);
            lo  = (top > win_len) ? top - win_len : 6'd0;
            win = low_mask(top) & ~low_mask(lo);
            hit_vec[j] = ((used & win) == '0) && (need <= 13'(j + 1));
        end
    end

    always_comb begin
        sel = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                sel = 5'(j);
            end
        end
    end

    always_comb begin
        top_used = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (used[i]) begin
                top_used = 5'(i);
            end
        end
    end

    assign start_pg = {1'b0, i_word_idx, sel} + 13'd1 - i_count;

    always_comb begin
        o_res.hit   = |hit_vec;
        o_res.found = start_pg[PAGE_W-1:0];
        if (used == '0) begin
            o_res.run = i_run + 13'd32;
        end else begin
            o_res.run = {8'd0, 5'd31 - top_used};
        end
    end

endmodule

// ----- sv/page_bitmap_allocator_core.sv -----
// Top level of the page bitmap allocator: request sequencer around the bitmap RAM.
//
// Usage:
//   Requests: drive i_req and raise start; the item is taken at an edge where
//   start is high and busy is low. Allocate scans the bitmap first-fit for a
//   free run of page_count pages; free, mark and query work on a given run.
//   Results: o_valid is high for exactly one cycle with o_result; the receiver
//   must take it then, there is no back-pressure.
//   Config: i_cfg_we/i_cfg_data write total_pages; write only while idle.
// Sequence from the accept edge to o_valid, one RAM word read per cycle:
//   bad request ............ result registered at the accept edge
//   free / mark / query .... S_RUN_START, then S_RUN for each word of the run
//   allocate ............... S_SCAN per word scanned, then as above for the run
//                            found (ceil(limit/32) words scanned when none fits)
// busy is low while o_valid is high, so the next item can be taken at its end.
// Reset: a clearing pass writes zero to every bitmap word, one per cycle,
// with busy high throughout; config writes are taken meanwhile.
module page_bitmap_allocator_core import pba_pkg::*; #(
    parameter int unsigned NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_request           i_req,
    output logic               o_valid,
    output t_result            o_result,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    localparam int unsigned WORDS   = (NUM_PAGES + 31) / 32;
    localparam int unsigned AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned LIM_CAP = (NUM_PAGES > 8191) ? 8191 : NUM_PAGES;

    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_SCAN      = 3'd2;
    localparam logic [2:0] S_RUN_START = 3'd3;
    localparam logic [2:0] S_RUN       = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [WIDX_W-1:0]  r_cur, n_cur;
    logic [COUNT_W-1:0] r_run, n_run;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [1:0]         r_op, n_op;
    logic [PAGE_W-1:0]  r_first, n_first;
    logic [PAGE_W-1:0]  r_last, n_last;
    logic               r_any, n_any;
    logic               r_valid, n_valid;
    t_result            r_res, n_res;
    logic [COUNT_W-1:0] r_total;

    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] lim_m1;
    logic [WIDX_W-1:0]  scan_last;
    logic [COUNT_W:0]   run_end;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    t_scan              scan;
    logic [WORD_W-1:0]  run_mask;
    logic               any_now;

    assign limit     = (r_total > COUNT_W'(LIM_CAP)) ? COUNT_W'(LIM_CAP) : r_total;
    assign lim_m1    = limit - 13'd1;
    assign scan_last = lim_m1[11:5];
    assign run_end   = {2'b00, i_req.page_index} + {1'b0, i_req.page_count};

    pba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pba_scan u_scan (
        .i_word     (ram_rdata),
        .i_word_idx (r_cur),
        .i_run      (r_run),
        .i_count    (r_count),
        .i_limit    (limit),
        .o_res      (scan)
    );

    // bits of the current word that belong to the run
    assign run_mask = range_mask((r_cur == r_first[11:5]) ? r_first[4:0] : 5'd0,
                                 (r_cur == r_last[11:5])  ? r_last[4:0]  : 5'd31);
    assign any_now  = r_any | ((ram_rdata & run_mask) != '0);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_cur     = r_cur;
        n_run     = r_run;
        n_count   = r_count;
        n_op      = r_op;
        n_first   = r_first;
        n_last    = r_last;
        n_any     = r_any;
        n_valid   = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = AW'(r_cur);
        ram_wdata = '0;
        ram_raddr = AW'(r_cur + 7'd1);

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op    = i_req.req_type;
                    n_count = i_req.page_count;
                    n_any   = 1'b0;
                    priority if (i_req.page_count == '0) begin
                        n_valid = 1'b1;
                        n_res   = '{status: ST_BAD, found_page: '0, any_used: 1'b0};
                    end else if (i_req.req_type == REQ_ALLOC) begin
                        if (i_req.page_count > limit) begin
                            n_valid = 1'b1;
                            n_res   = '{status: ST_BAD, found_page: '0, any_used: 1'b0};
                        end else begin
                            ram_raddr = AW'(0);
                            n_cur     = '0;
                            n_run     = '0;
                            n_state   = S_SCAN;
                        end
                    end else if (run_end > {1'b0, limit}) begin
                        n_valid = 1'b1;
                        n_res   = '{status: ST_BAD, found_page: '0, any_used: 1'b0};
                    end else begin
                        n_first = i_req.page_index;
                        n_last  = PAGE_W'(run_end - 14'd1);
                        n_state = S_RUN_START;
                    end
                end
            end
            S_SCAN: begin
                priority if (scan.hit) begin
                    n_first = scan.found;
                    n_last  = PAGE_W'({1'b0, scan.found} + r_count - 13'd1);
                    n_state = S_RUN_START;
                end else if (r_cur == scan_last) begin
                    n_valid = 1'b1;
                    n_res   = '{status: ST_NOFIT, found_page: '0, any_used: 1'b0};
                    n_state = S_IDLE;
                end else begin
                    n_cur = r_cur + 7'd1;
                    n_run = scan.run;
                end
            end
            S_RUN_START: begin
                ram_raddr = AW'(r_first[11:5]);
                n_cur     = r_first[11:5];
                n_state   = S_RUN;
            end
            S_RUN: begin
                // read-modify-write; the next word's read overlaps this write
                if (r_op != REQ_QUERY) begin
                    ram_we    = 1'b1;
                    ram_wdata = (r_op == REQ_FREE) ? (ram_rdata & ~run_mask)
                                                   : (ram_rdata | run_mask);
                end
                if (r_cur == r_last[11:5]) begin
                    n_valid = 1'b1;
                    n_res.status     = ST_OK;
                    n_res.found_page = (r_op == REQ_ALLOC) ? r_first : '0;
                    n_res.any_used   = (r_op == REQ_QUERY) ? any_now : 1'b0;
                    n_state          = S_IDLE;
                end else begin
                    n_cur = r_cur + 7'd1;
                    n_any = any_now;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_total <= TOTAL_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_run   <= n_run;
        r_count <= n_count;
        r_op    <= n_op;
        r_first <= n_first;
        r_last  <= n_last;
        r_any   <= n_any;
        r_res   <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule
